// ----- hw/rtl/ppce_pkg.sv -----
// Package for the planar plot cache engine: shared types, codes and
// address helpers. Used by every module of the block but ppce_ram.
package ppce_pkg;

  localparam int RAM_ADDR_BITS = 17;
  localparam int RAM_DEPTH     = 1 << RAM_ADDR_BITS;

  localparam logic [1:0] OP_PLOT     = 2'd0;
  localparam logic [1:0] OP_READ_PIX = 2'd1;
  localparam logic [1:0] OP_HOST_WR  = 2'd2;
  localparam logic [1:0] OP_HOST_RD  = 2'd3;

  localparam logic [2:0] REG_BPP    = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_OBJ    = 3'd2;
  localparam logic [2:0] REG_BASE   = 3'd3;
  localparam logic [2:0] REG_OPAQUE = 3'd4;
  localparam logic [2:0] REG_DITHER = 3'd5;
  localparam logic [2:0] REG_FREEZE = 3'd6;

  typedef struct packed {
    logic [1:0] bpp_mode;
    logic [1:0] height_mode;
    logic       obj_layout;
    logic [7:0] frame_base;
    logic       plot_opaque_zero;
    logic       dither_on;
    logic       freeze_high;
  } cfg_t;

  // One classified item as it sits in the queue
  typedef struct packed {
    logic [1:0]               op;
    logic                     skip;
    logic [7:0]               px;
    logic [7:0]               py;
    logic [7:0]               color;
    logic [RAM_ADDR_BITS-1:0] addr;
    logic [7:0]               wdata;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [4:0] bytes_written;
  } result_t;

  // Highest plane index: 1, 3 or 7
  function automatic logic [2:0] plane_max(input logic [1:0] bpp);
    case (bpp)
      2'd0:    plane_max = 3'd1;
      2'd1:    plane_max = 3'd3;
      default: plane_max = 3'd7;
    endcase
  endfunction

  function automatic logic [9:0] tile_index(input cfg_t c, input logic [7:0] x,
                                            input logic [7:0] y);
    logic [9:0] xg;
    logic [9:0] yg;
    logic [1:0] lay;
    xg  = {2'b00, x & 8'hF8};
    yg  = {5'd0, y[7:3]};
    lay = c.obj_layout ? 2'd3 : c.height_mode;
    case (lay)
      2'd1:    tile_index = (xg << 1) + (xg >> 1) + yg;
      2'd2:    tile_index = (xg << 1) + xg + yg;
      2'd3:    tile_index = {y[7], x[7], y[6:3], x[6:3]};
      default: tile_index = (xg << 1) + yg;
    endcase
  endfunction

  // Address of plane 0 of the row that holds pixel (x, y)
  function automatic logic [RAM_ADDR_BITS-1:0] row_base(input cfg_t c,
                                                       input logic [7:0] x,
                                                       input logic [7:0] y);
    logic [19:0] t;
    logic [19:0] sum;
    t = {10'd0, tile_index(c, x, y)};
    case (c.bpp_mode)
      2'd0:    t = t << 4;
      2'd1:    t = t << 5;
      default: t = t << 6;
    endcase
    sum = ({12'd0, c.frame_base} << 10) + t + {16'd0, y[2:0], 1'b0};
    row_base = sum[RAM_ADDR_BITS-1:0];
  endfunction

  function automatic logic [RAM_ADDR_BITS-1:0] plane_off(input logic [2:0] p);
    plane_off = RAM_ADDR_BITS'({p[2:1], 3'b000, p[0]});
  endfunction

endpackage

// ----- hw/rtl/ppce_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
module ppce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- hw/rtl/ppce_front.sv -----
// Front part: classifies input items and queues them (two entries).
// Depends on ppce_pkg.
module ppce_front (
  input  logic           clk,
  input  logic           rst_n,
  input  ppce_pkg::cfg_t cfg,
  input  logic           in_valid,
  output logic           in_ready,
  input  ppce_pkg::item_t in_item,
  output logic           q_valid,
  input  logic           q_pop,
  output ppce_pkg::item_t q_item
);
  import ppce_pkg::*;

  item_t       slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  item_t       cls;
  logic [7:0]  tcol;
  logic [7:0]  mask;
  logic        push;

  // Dither uses the raw color; transparency the freeze-masked one
  always_comb begin
    cls  = in_item;
    tcol = cfg.freeze_high ? (in_item.color & 8'h0F) : in_item.color;
    case (cfg.bpp_mode)
      2'd0:    mask = 8'h03;
      2'd1:    mask = 8'h0F;
      default: mask = 8'hFF;
    endcase
    cls.skip = !cfg.plot_opaque_zero && ((tcol & mask) == 8'h00);
    if (cfg.dither_on && !cfg.bpp_mode[1]) begin
      cls.color = (in_item.px[0] ^ in_item.py[0]) ? (in_item.color >> 4)
                                                  : (in_item.color & 8'h0F);
    end
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      slot_r[wr_ptr_r] <= cls;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != 2'd0) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count overflow");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !q_pop) |=> cnt_r == 2'd2) else $error("full queue lost entry");
`endif
endmodule

// ----- hw/rtl/ppce_back.sv -----
// Back part: row caches, flush sequencer and frame RAM port.
// Depends on ppce_pkg and ppce_ram.
module ppce_back (
  input  logic             clk,
  input  logic             rst_n,
  input  ppce_pkg::cfg_t   cfg,
  input  logic             q_valid,
  output logic             q_pop,
  input  ppce_pkg::item_t  q_item,
  output logic             res_valid,
  input  logic             res_ready,
  output ppce_pkg::result_t res
);
  import ppce_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EXEC     = 4'd1;
  localparam logic [3:0] S_WO_RD    = 4'd2;
  localparam logic [3:0] S_WO_WR    = 4'd3;
  localparam logic [3:0] S_AFTER    = 4'd4;
  localparam logic [3:0] S_GATH_RD  = 4'd5;
  localparam logic [3:0] S_GATH_DAT = 4'd6;
  localparam logic [3:0] S_HOST_DAT = 4'd7;
  localparam logic [3:0] S_OUT      = 4'd8;

  localparam logic [1:0] PH_MISS = 2'd0;
  localparam logic [1:0] PH_FULL = 2'd1;
  localparam logic [1:0] PH_RD1  = 2'd2;
  localparam logic [1:0] PH_RD2  = 2'd3;

  logic [3:0]  state_r, state_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [2:0]  plane_r, plane_nxt;
  logic [4:0]  wcnt_r, wcnt_nxt;
  logic [7:0]  rd_r, rd_nxt;
  item_t       it_r;
  logic [RAM_ADDR_BITS-1:0] base_r, base_nxt;

  logic [4:0]  pri_col_r, pri_col_nxt;
  logic [7:0]  pri_row_r, pri_row_nxt;
  logic [7:0]  pri_valid_r, pri_valid_nxt;
  logic [7:0]  pri_pix_r [8];
  logic [4:0]  sec_col_r, sec_col_nxt;
  logic [7:0]  sec_row_r, sec_row_nxt;
  logic [7:0]  sec_valid_r, sec_valid_nxt;
  logic [7:0]  sec_pix_r [8];
  logic        pix_wr;
  logic        sec_copy;

  logic        out_valid_r, out_valid_nxt;
  result_t     out_r;
  logic        out_load;

  logic        ram_we;
  logic [RAM_ADDR_BITS-1:0] ram_addr;
  logic [7:0]  ram_wdata, ram_rdata;
  logic [7:0]  tpos;
  logic [2:0]  pmax;
  logic [2:0]  bitsel;
  logic        hit;
  logic [7:0]  ins_valid;

  ppce_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign pmax      = plane_max(cfg.bpp_mode);
  assign bitsel    = ~it_r.px[2:0];
  assign hit       = (pri_col_r == it_r.px[7:3]) && (pri_row_r == it_r.py);
  assign ins_valid = pri_valid_r | (8'd1 << bitsel);
  assign res_valid = out_valid_r;
  assign res       = out_r;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || res_ready);

  // Transpose one plane of the secondary row
  always_comb begin
    for (int b = 0; b < 8; b++) begin
      tpos[b] = sec_pix_r[b][plane_r];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    plane_nxt     = plane_r;
    wcnt_nxt      = wcnt_r;
    rd_nxt        = rd_r;
    base_nxt      = base_r;
    pri_col_nxt   = pri_col_r;
    pri_row_nxt   = pri_row_r;
    pri_valid_nxt = pri_valid_r;
    sec_col_nxt   = sec_col_r;
    sec_row_nxt   = sec_row_r;
    sec_valid_nxt = sec_valid_r;
    pix_wr        = 1'b0;
    sec_copy      = 1'b0;
    q_pop         = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = base_r + plane_off(plane_r);
    ram_wdata     = 8'h00;
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          wcnt_nxt  = 5'd0;
          rd_nxt    = 8'h00;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (it_r.op)
          OP_PLOT: begin
            if (it_r.skip) begin
              state_nxt = S_OUT;
            end else if (!hit) begin
              phase_nxt = PH_MISS;
              state_nxt = S_AFTER;
            end else begin
              pix_wr        = 1'b1;
              pri_valid_nxt = ins_valid;
              phase_nxt     = PH_FULL;
              state_nxt     = (ins_valid == 8'hFF) ? S_AFTER : S_OUT;
            end
          end
          OP_READ_PIX: begin
            phase_nxt = PH_RD1;
            state_nxt = S_AFTER;
          end
          OP_HOST_WR: begin
            ram_we    = 1'b1;
            ram_addr  = it_r.addr;
            ram_wdata = it_r.wdata;
            state_nxt = S_OUT;
          end
          default: begin
            ram_addr  = it_r.addr;
            state_nxt = S_HOST_DAT;
          end
        endcase
        // Write out the secondary row first where the path needs it
        if (state_nxt == S_AFTER && sec_valid_r != 8'h00) begin
          base_nxt  = row_base(cfg, {sec_col_r, 3'b000}, sec_row_r);
          plane_nxt = 3'd0;
          wcnt_nxt  = wcnt_r + {2'b00, pmax} + 5'd1;
          state_nxt = (sec_valid_r == 8'hFF) ? S_WO_WR : S_WO_RD;
        end
      end
      S_WO_RD: begin
        state_nxt = S_WO_WR;
      end
      S_WO_WR: begin
        ram_we    = 1'b1;
        ram_wdata = (sec_valid_r == 8'hFF) ? tpos
                  : ((tpos & sec_valid_r) | (ram_rdata & ~sec_valid_r));
        plane_nxt = plane_r + 3'd1;
        if (plane_r == pmax) begin
          sec_valid_nxt = 8'h00;
          state_nxt     = S_AFTER;
        end else begin
          state_nxt = (sec_valid_r == 8'hFF) ? S_WO_WR : S_WO_RD;
        end
      end
      S_AFTER: begin
        case (phase_r)
          PH_MISS, PH_FULL: begin
            // Spill: primary moves down, primary tag takes the new row
            sec_copy      = 1'b1;
            sec_col_nxt   = pri_col_r;
            sec_row_nxt   = pri_row_r;
            sec_valid_nxt = pri_valid_r;
            pri_col_nxt   = it_r.px[7:3];
            pri_row_nxt   = it_r.py;
            pri_valid_nxt = 8'h00;
            if (phase_r == PH_MISS) begin
              pix_wr        = 1'b1;
              pri_valid_nxt = 8'd1 << bitsel;
            end
            state_nxt = S_OUT;
          end
          PH_RD1: begin
            // Move the primary row down and write it out; tag stays
            sec_copy      = 1'b1;
            sec_col_nxt   = pri_col_r;
            sec_row_nxt   = pri_row_r;
            sec_valid_nxt = pri_valid_r;
            pri_valid_nxt = 8'h00;
            phase_nxt     = PH_RD2;
            if (pri_valid_r != 8'h00) begin
              base_nxt  = row_base(cfg, {pri_col_r, 3'b000}, pri_row_r);
              plane_nxt = 3'd0;
              wcnt_nxt  = wcnt_r + {2'b00, pmax} + 5'd1;
              state_nxt = (pri_valid_r == 8'hFF) ? S_WO_WR : S_WO_RD;
            end
          end
          default: begin
            base_nxt  = row_base(cfg, it_r.px, it_r.py);
            plane_nxt = 3'd0;
            state_nxt = S_GATH_RD;
          end
        endcase
      end
      S_GATH_RD: begin
        state_nxt = S_GATH_DAT;
      end
      S_GATH_DAT: begin
        rd_nxt[plane_r] = ram_rdata[bitsel];
        plane_nxt       = plane_r + 3'd1;
        state_nxt       = (plane_r == pmax) ? S_OUT : S_GATH_RD;
      end
      S_HOST_DAT: begin
        rd_nxt    = ram_rdata;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_MISS;
      plane_r     <= 3'd0;
      wcnt_r      <= 5'd0;
      rd_r        <= 8'h00;
      base_r      <= '0;
      pri_col_r   <= 5'd0;
      pri_row_r   <= 8'd0;
      pri_valid_r <= 8'd0;
      sec_col_r   <= 5'd0;
      sec_row_r   <= 8'd0;
      sec_valid_r <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      plane_r     <= plane_nxt;
      wcnt_r      <= wcnt_nxt;
      rd_r        <= rd_nxt;
      base_r      <= base_nxt;
      pri_col_r   <= pri_col_nxt;
      pri_row_r   <= pri_row_nxt;
      pri_valid_r <= pri_valid_nxt;
      sec_col_r   <= sec_col_nxt;
      sec_row_r   <= sec_row_nxt;
      sec_valid_r <= sec_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (q_pop) begin
      it_r <= q_item;
    end
    if (sec_copy) begin
      for (int b = 0; b < 8; b++) begin
        sec_pix_r[b] <= pri_pix_r[b];
      end
    end
    if (pix_wr) begin
      pri_pix_r[bitsel] <= it_r.color;
    end
    if (out_load) begin
      out_r.read_data     <= rd_r;
      out_r.bytes_written <= wcnt_r;
    end
  end

`ifndef NO_ASSERTIONS
  a_flushed_gather: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_GATH_RD |-> (pri_valid_r == 8'h00 && sec_valid_r == 8'h00))
    else $error("gather with dirty cache");
  a_wcnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    wcnt_r <= 5'd16) else $error("write count beyond two rows");
  a_plane_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WO_WR |-> plane_r <= pmax) else $error("plane index overrun");
  a_wo_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WO_RD |-> sec_valid_r != 8'h00 || phase_r == PH_RD2)
    else $error("write-out of empty row");
`endif
endmodule

// ----- hw/rtl/planar_plot_cache_engine.sv -----
// Top level of the planar plot cache engine: register file, front queue and back part.
// Depends on ppce_pkg, ppce_front, ppce_back (and ppce_ram below it).
//
//  Channel | Direction | Transfer when           | Content
//  in_     | in        | in_tvalid & in_tready   | op in tuser, pixel/host fields in tdata
//  out_    | out       | out_tvalid & out_tready | read_data, bytes_written
//  cfg_    | in        | psel&penable&pwrite     | seven mode registers at 4*i
//
// A plot that hits the primary row goes through pop, execute and the result register
// in the back part; a spill adds the S_AFTER step and first, per plane of a non-empty
// secondary row, a read and then a write (a full row skips the read).
// A pixel read flushes both rows and gathers each plane with a read and a data step.
// All of this runs on the single frame RAM port. Reset is synchronous, active low;
// frame RAM contents are not cleared. A two-entry queue keeps accepting items, until
// it is full, while the back part works or a result waits on a stalled output.
module planar_plot_cache_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // px, py, plot_color, ram_addr[16:0], ram_wdata
  input  logic [1:0]  in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // read_data, bytes_written
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ppce_pkg::*;

  cfg_t    cfg_r;
  item_t   in_item;
  item_t   q_item;
  logic    q_valid;
  logic    q_pop;
  logic    res_valid;
  result_t res;
  logic    cfg_wr;
  logic [2:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[4:2];

  // Unpack the stream payload; skip is filled in by the front part
  always_comb begin
    in_item.op    = in_tuser;
    in_item.skip  = 1'b0;
    in_item.px    = in_tdata[7:0];
    in_item.py    = in_tdata[15:8];
    in_item.color = in_tdata[23:16];
    in_item.addr  = in_tdata[24 +: RAM_ADDR_BITS];
    in_item.wdata = in_tdata[48:41];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BPP:    cfg_r.bpp_mode         <= cfg_pwdata[1:0];
        REG_HEIGHT: cfg_r.height_mode      <= cfg_pwdata[1:0];
        REG_OBJ:    cfg_r.obj_layout       <= cfg_pwdata[0];
        REG_BASE:   cfg_r.frame_base       <= cfg_pwdata[7:0];
        REG_OPAQUE: cfg_r.plot_opaque_zero <= cfg_pwdata[0];
        REG_DITHER: cfg_r.dither_on        <= cfg_pwdata[0];
        REG_FREEZE: cfg_r.freeze_high      <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BPP:    cfg_prdata = {30'd0, cfg_r.bpp_mode};
      REG_HEIGHT: cfg_prdata = {30'd0, cfg_r.height_mode};
      REG_OBJ:    cfg_prdata = {31'd0, cfg_r.obj_layout};
      REG_BASE:   cfg_prdata = {24'd0, cfg_r.frame_base};
      REG_OPAQUE: cfg_prdata = {31'd0, cfg_r.plot_opaque_zero};
      REG_DITHER: cfg_prdata = {31'd0, cfg_r.dither_on};
      REG_FREEZE: cfg_prdata = {31'd0, cfg_r.freeze_high};
      default:    cfg_prdata = 32'd0;
    endcase
  end

  ppce_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_item   (q_item)
  );

  ppce_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .res_valid (res_valid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = {3'd0, res.bytes_written, res.read_data};
endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for planar_plot_cache_engine: streams plot, pixel-read and
// host RAM items, predicts every result in a scoreboard class. Depends on ppce_pkg.
module tb_top;
  import ppce_pkg::*;

  localparam int RAM_MASK = RAM_DEPTH - 1;
  localparam int SETTLE   = 80;  // a pixel read flush plus gather stays well below this

  // One cached row of eight pixels, pixel 7 is the leftmost
  typedef struct packed {
    bit [4:0]      col;
    bit [7:0]      row;
    bit [7:0][7:0] pix;
    bit [7:0]      valid;
  } row_buf_t;

  // Mirror of the cache engine: registers, both row buffers and frame RAM
  class plot_scoreboard;
    cfg_t     cfg;
    row_buf_t front;   // primary row
    row_buf_t back;    // secondary row
    bit [7:0] ram [RAM_DEPTH];
    bit       known [RAM_DEPTH];
    result_t  pending [$];
    int       errors;
    int       checked;

    function void set_reg(input logic [2:0] idx, input logic [7:0] v);
      case (idx)
        REG_BPP:    cfg.bpp_mode = v[1:0];
        REG_HEIGHT: cfg.height_mode = v[1:0];
        REG_OBJ:    cfg.obj_layout = v[0];
        REG_BASE:   cfg.frame_base = v;
        REG_OPAQUE: cfg.plot_opaque_zero = v[0];
        REG_DITHER: cfg.dither_on = v[0];
        REG_FREEZE: cfg.freeze_high = v[0];
        default: ;
      endcase
    endfunction

    function int planes();
      case (cfg.bpp_mode)
        2'd0:    return 2;
        2'd1:    return 4;
        default: return 8;
      endcase
    endfunction

    function int tile_of(input int x, input int y);
      int xs;
      int yg;
      xs = x & 'hF8;
      yg = (y & 'hF8) >> 3;
      if (cfg.obj_layout)
        return ((y & 'h80) << 2) + ((x & 'h80) << 1) + ((y & 'h78) << 1) + ((x & 'h78) >> 3);
      case (cfg.height_mode)
        2'd1:    return (xs << 1) + (xs >> 1) + yg;
        2'd2:    return (xs << 1) + xs + yg;
        2'd3:    return ((y & 'h80) << 2) + ((x & 'h80) << 1) + ((y & 'h78) << 1)
                        + ((x & 'h78) >> 3);
        default: return (xs << 1) + yg;
      endcase
    endfunction

    function int plane_addr(input int x, input int y, input int p);
      return ((int'(cfg.frame_base) << 10) + tile_of(x, y) * planes() * 8 + (y & 7) * 2
              + (p >> 1) * 16 + (p & 1)) & RAM_MASK;
    endfunction

    // Transpose one row into its planes, merging a partial row with RAM
    function int store_row(inout row_buf_t r);
      int a;
      bit [7:0] v;
      if (r.valid == 0) return 0;
      for (int p = 0; p < planes(); p++) begin
        a = plane_addr(int'(r.col) << 3, int'(r.row), p);
        for (int b = 0; b < 8; b++) v[b] = r.pix[b][p];
        if (r.valid != 8'hFF) v = (v & r.valid) | (ram[a] & ~r.valid);
        ram[a] = v;
        known[a] = 1;
      end
      r.valid = 0;
      return planes();
    endfunction

    function int spill(input bit [7:0] x, input bit [7:0] y);
      int n;
      n = store_row(back);
      back = front;
      front.valid = 0;
      front.col = x[7:3];
      front.row = y;
      return n;
    endfunction

    function int plot(input bit [7:0] x, input bit [7:0] y, input bit [7:0] c);
      int n;
      int bit_i;
      bit [7:0] t;
      bit [7:0] m;
      n = 0;
      t = cfg.freeze_high ? (c & 8'h0F) : c;
      m = planes() == 2 ? 8'h03 : (planes() == 4 ? 8'h0F : 8'hFF);
      if (!cfg.plot_opaque_zero && (t & m) == 0) return 0;
      if (cfg.dither_on && planes() != 8) begin
        if (x[0] ^ y[0]) c = c >> 4;
        c = c & 8'h0F;
      end
      if (front.col != x[7:3] || front.row != y) n += spill(x, y);
      bit_i = int'(x[2:0] ^ 3'd7);
      front.pix[bit_i] = c;
      front.valid[bit_i] = 1;
      if (front.valid == 8'hFF) n += spill(x, y);
      return n;
    endfunction

    // Note an accepted input transfer and queue its result
    function void note(input logic [1:0] op, input bit [7:0] x, input bit [7:0] y,
                       input bit [7:0] c, input bit [16:0] a, input bit [7:0] wd);
      result_t r;
      int n;
      bit [7:0] v;
      n = 0;
      r.read_data = 8'd0;
      case (op)
        OP_PLOT: n = plot(x, y, c);
        OP_READ_PIX: begin
          n = store_row(back);
          n += store_row(front);
          for (int p = 0; p < planes(); p++) begin
            v = ram[plane_addr(int'(x), int'(y), p)];
            r.read_data[p] = v[x[2:0] ^ 3'd7];
          end
        end
        OP_HOST_WR: begin
          ram[a] = wd;
          known[a] = 1;
        end
        default: r.read_data = ram[a];
      endcase
      r.bytes_written = n[4:0];
      pending.push_back(r);
    endfunction

    // Compare one result transfer with the oldest expectation
    function void check(input logic [7:0] rd, input logic [4:0] bw);
      result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result rd=%0h bw=%0d", $time, rd, bw);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (rd !== e.read_data) begin
        $display("%0t: read_data expected %0h actual %0h", $time, e.read_data, rd);
        errors++;
      end
      if (bw !== e.bytes_written) begin
        $display("%0t: bytes_written expected %0d actual %0d", $time, e.bytes_written, bw);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // px, py, plot_color, ram_addr[16:0], ram_wdata
  logic [1:0]  in_tuser;   // op
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // read_data, bytes_written
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  planar_plot_cache_engine dut (.*);

  plot_scoreboard pix_model;
  int host_addrs [$];   // bytes known to hold data, for host reads
  bit driving;          // in_tvalid is being held high
  int burst_left;
  int gap;
  int n_sent;
  int stall_tick;
  int stall_mode;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(4 * 3000000);
    $display("CHECK FAILED");
    $finish;
  end

  // Receiver: stall pattern is redrawn from three modes, mode 0 never stalls
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) pix_model.check(out_tdata[7:0], out_tdata[12:8]);
    stall_tick <= stall_tick + 1;
    if (stall_tick % 256 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic new_burst();
    if ($urandom_range(0, 9) == 0) burst_left = 40;
    else burst_left = $urandom_range(1, 10);
    gap = $urandom_range(1, 6);
  endtask

  // Drive one item and hold it until its transfer
  task automatic send(input logic [1:0] op, input bit [7:0] x, input bit [7:0] y,
                      input bit [7:0] c, input bit [16:0] a, input bit [7:0] wd);
    if (!driving) repeat (gap) @(posedge clk);
    in_tuser  <= op;
    in_tdata  <= {7'd0, wd, a, c, y, x};
    in_tvalid <= 1'b1;
    driving = 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pix_model.note(op, x, y, c, a, wd);
    n_sent++;
    if (op == OP_HOST_WR) host_addrs.push_back(int'(a));
    burst_left--;
    if (burst_left <= 0) begin
      in_tvalid <= 1'b0;
      driving = 0;
      new_burst();
    end
  endtask

  // Drop valid and wait until every expected result has come
  task automatic drain();
    if (driving) begin
      in_tvalid <= 1'b0;
      driving = 0;
      gap = 1;
    end
    while (pix_model.pending.size() > 0) @(posedge clk);
  endtask

  // Load any unwritten plane byte of the row under (x, y) before touching it
  task automatic prime_row(input bit [7:0] x, input bit [7:0] y);
    int a;
    for (int p = 0; p < pix_model.planes(); p++) begin
      a = pix_model.plane_addr(int'(x), int'(y), p);
      if (!pix_model.known[a])
        send(OP_HOST_WR, 8'($urandom), 8'($urandom), 8'($urandom), 17'(a), 8'($urandom));
    end
  endtask

  task automatic plot_at(input bit [7:0] x, input bit [7:0] y, input bit [7:0] c);
    prime_row(x, y);
    send(OP_PLOT, x, y, c, 17'($urandom), 8'($urandom));
  endtask

  task automatic read_at(input bit [7:0] x, input bit [7:0] y);
    prime_row(x, y);
    send(OP_READ_PIX, x, y, 8'($urandom), 17'($urandom), 8'($urandom));
  endtask

  task automatic host_read_any();
    bit [16:0] a;
    a = 17'(host_addrs[$urandom_range(0, host_addrs.size() - 1)]);
    send(OP_HOST_RD, 8'($urandom), 8'($urandom), 8'($urandom), a, 8'($urandom));
  endtask

  // Setup cycle, then access cycle; the write lands on the access edge
  task automatic reg_write(input logic [2:0] idx, input logic [7:0] v);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {24'd0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    pix_model.set_reg(idx, v);
  endtask

  task automatic load_setting(input bit [1:0] bpp, input bit [1:0] hgt, input bit obj,
                              input bit [7:0] base, input bit opq, input bit dth,
                              input bit frz);
    reg_write(REG_BPP, 8'(bpp));
    reg_write(REG_HEIGHT, 8'(hgt));
    reg_write(REG_OBJ, 8'(obj));
    reg_write(REG_BASE, base);
    reg_write(REG_OPAQUE, 8'(opq));
    reg_write(REG_DITHER, 8'(dth));
    reg_write(REG_FREEZE, 8'(frz));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Mostly row runs so that rows fill, spill and merge; the rest is mixed traffic
  task automatic random_traffic(input int count);
    int stop_at;
    int hold_at;
    int pick;
    bit [7:0] y;
    bit [7:0] x;
    stop_at = n_sent + count;
    hold_at = n_sent + int'($urandom_range(10, count - 10));
    while (n_sent < stop_at) begin
      if (n_sent >= hold_at && hold_at > 0) begin
        drain();
        hold_at = 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        y = 8'($urandom);
        x = 8'($urandom) & 8'hF8;
        if ($urandom_range(0, 2) == 0) begin
          for (int i = 0; i < 8; i++) plot_at(x | 8'(i), y, 8'($urandom));
        end else begin
          repeat ($urandom_range(1, 6))
            plot_at(x | 8'($urandom_range(0, 7)), y,
                    ($urandom_range(0, 4) == 0) ? 8'd0 : 8'($urandom));
        end
      end else if (pick < 72) begin
        plot_at(8'($urandom), 8'($urandom), 8'($urandom));
      end else if (pick < 84) begin
        read_at(8'($urandom), 8'($urandom));
      end else if (pick < 93) begin
        send(OP_HOST_WR, 8'($urandom), 8'($urandom), 8'($urandom), 17'($urandom),
             8'($urandom));
      end else begin
        host_read_any();
      end
    end
  endtask

  initial begin
    pix_model   = new();
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = OP_PLOT;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    stall_tick  = 0;
    stall_mode  = 0;
    driving     = 0;
    n_sent      = 0;
    new_burst();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under reset settings: two planes, transparency on
    send(OP_HOST_WR, 8'd0, 8'd0, 8'd0, 17'h1FFFF, 8'hFF);
    send(OP_HOST_WR, 8'hFF, 8'hFF, 8'hFF, 17'h00000, 8'h00);
    send(OP_HOST_RD, 8'd0, 8'd0, 8'd0, 17'h1FFFF, 8'd0);
    send(OP_HOST_RD, 8'd0, 8'd0, 8'd0, 17'h00000, 8'd0);
    read_at(8'd0, 8'd0);            // both rows empty: nothing written
    plot_at(8'd3, 8'd0, 8'd0);      // transparent, dropped
    plot_at(8'd3, 8'd0, 8'hFC);     // low bits zero: still transparent
    for (int i = 0; i < 8; i++) plot_at(8'(i), 8'd0, 8'(i + 1));   // six kept, 4 and 8 drop
    plot_at(8'd255, 8'd255, 8'hFF); // row change with a partial row behind it
    plot_at(8'd250, 8'd255, 8'h02);
    plot_at(8'd17, 8'd9, 8'h01);    // writes out row 0 with a merge read; row 255 moves down
    read_at(8'd255, 8'd255);
    read_at(8'd2, 8'd0);
    send(OP_HOST_RD, 8'd0, 8'd0, 8'd0, 17'h1FFFF, 8'd0);
    random_traffic(100);

    for (int ph = 1; ph <= 7; ph++) begin
      // Flush both rows, let the block settle, then switch settings
      read_at(8'($urandom), 8'($urandom));
      drain();
      repeat (SETTLE) @(posedge clk);
      case (ph)
        1: load_setting(2'd1, 2'd1, 1'b0, 8'hFF, 1'b1, 1'b0, 1'b0);
        2: load_setting(2'd2, 2'd2, 1'b0, 8'h40, 1'b0, 1'b1, 1'b1);
        3: load_setting(2'd3, 2'd3, 1'b0, 8'h01, 1'b1, 1'b1, 1'b0);
        4: load_setting(2'd0, 2'd0, 1'b1, 8'h00, 1'b0, 1'b1, 1'b1);
        5: load_setting(2'd1, 2'd2, 1'b1, 8'h80, 1'b0, 1'b0, 1'b1);
        6: load_setting(2'($urandom), 2'($urandom), 1'($urandom), 8'($urandom),
                        1'($urandom), 1'($urandom), 1'($urandom));
        default: load_setting(2'd0, 2'd3, 1'b0, 8'hFF, 1'b1, 1'b1, 1'b1);
      endcase
      random_traffic(110);
    end

    read_at(8'($urandom), 8'($urandom));
    drain();
    repeat (SETTLE) @(posedge clk);
    $display("Run: %0d items over 8 register settings, %0d results checked",
             n_sent, pix_model.checked);
    $display("Covered 2/4/8 planes, all tile layouts, dither, freeze and opaque modes");
    if (pix_model.errors == 0 && pix_model.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
